// File: rtl/lqrsf_pkg.sv
package lqrsf_pkg;

	// sizes
	localparam int N_STATES_DEF = 12;
	localparam int N_OUTPUTS    = 4;
	localparam int FRAC_BITS    = 16;
	localparam int DATA_W       = 32;
	localparam int ACC_W        = 64;
	localparam int SLOT_W       = 6;
	localparam int SHR_W        = ACC_W - FRAC_BITS;
	localparam int FIN_W        = SHR_W + 2;

	// item kinds
	localparam logic KIND_GAIN  = 1'b0;
	localparam logic KIND_STATE = 1'b1;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_ALTITUDE_TARGET = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_YAW_TARGET      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HOVER_THRUST    = 2'd2;

	// register reset values, q16.16
	localparam logic signed [DATA_W-1:0] ALTITUDE_TARGET_RST = -32'sd1310720;
	localparam logic signed [DATA_W-1:0] YAW_TARGET_RST      = -32'sd12452;
	localparam logic signed [DATA_W-1:0] HOVER_THRUST_RST    = 32'sd1561735;

	// state elements that carry a target offset
	localparam logic [SLOT_W-1:0] ALT_INDEX = 6'd2;
	localparam logic [SLOT_W-1:0] YAW_INDEX = 6'd5;

	typedef struct packed {
		logic                     kind;
		logic [SLOT_W-1:0]        slot;
		logic signed [DATA_W-1:0] value;
	} item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] out_thrust;
		logic signed [DATA_W-1:0] out_roll;
		logic signed [DATA_W-1:0] out_pitch;
		logic signed [DATA_W-1:0] out_yaw;
	} result_t;

	// per-stage control of the element pipeline
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} stage_ctl_t;

endpackage

// File: rtl/lqrsf_gain_mem.sv
module lqrsf_gain_mem #(
	parameter int N_STATES = lqrsf_pkg::N_STATES_DEF
) (
	input  logic                                                  clk,
	input  logic                                                  we,
	input  logic [lqrsf_pkg::SLOT_W-1:0]                          wslot,
	input  logic [lqrsf_pkg::DATA_W-1:0]                          wdata,
	input  logic                                                  re,
	input  logic [$clog2(N_STATES)-1:0]                           raddr,
	output logic [lqrsf_pkg::N_OUTPUTS-1:0][lqrsf_pkg::DATA_W-1:0] rd_s1
);

	localparam int IDX_W = $clog2(N_STATES);

	// one row per state index, one lane per output
	logic [lqrsf_pkg::N_OUTPUTS-1:0][lqrsf_pkg::DATA_W-1:0] gain_q [N_STATES];

	// lane write decoded from row*N_STATES+column, registered row read
	always_ff @(posedge clk) begin
		if (we) begin
			for (int r = 0; r < lqrsf_pkg::N_OUTPUTS; r++) begin
				if (32'(wslot) >= 32'(r * N_STATES) &&
				    32'(wslot) < 32'((r + 1) * N_STATES)) begin
					gain_q[IDX_W'(32'(wslot) - 32'(r * N_STATES))][r] <= wdata;
				end
			end
		end
		if (re) begin
			rd_s1 <= gain_q[raddr];
		end
	end

endmodule

// File: rtl/lqrsf_mac.sv
module lqrsf_mac #(
	parameter int N_STATES = lqrsf_pkg::N_STATES_DEF
) (
	input  logic                                                 clk,
	input  logic                                                 arst_n,
	input  logic                                                 adv,
	input  logic                                                 take,
	input  logic [lqrsf_pkg::SLOT_W-1:0]                         slot,
	input  logic signed [lqrsf_pkg::DATA_W-1:0]                  value,
	input  logic signed [lqrsf_pkg::DATA_W-1:0]                  altitude_target,
	input  logic signed [lqrsf_pkg::DATA_W-1:0]                  yaw_target,
	input  logic [lqrsf_pkg::N_OUTPUTS-1:0][lqrsf_pkg::DATA_W-1:0] gain_s1,
	output logic                                                 valid_s3,
	output logic [lqrsf_pkg::N_OUTPUTS-1:0][lqrsf_pkg::ACC_W-1:0] sum_s3
);

	localparam int DW = lqrsf_pkg::DATA_W;
	localparam int AW = lqrsf_pkg::ACC_W;
	localparam int NO = lqrsf_pkg::N_OUTPUTS;

	logic signed [DW-1:0] target;
	logic                 offset_en;
	logic signed [DW:0]   diff;
	logic signed [DW-1:0] elem;

	lqrsf_pkg::stage_ctl_t ctl_s1;
	lqrsf_pkg::stage_ctl_t ctl_s2;
	logic signed [DW-1:0]  elem_s1;
	logic [NO-1:0][AW-1:0] prod_s2;
	logic [NO-1:0][AW-1:0] acc_q;
	logic [NO-1:0][AW-1:0] sum_nxt;

	// target offset on the altitude and yaw elements, saturated
	always_comb begin
		offset_en = (slot == lqrsf_pkg::ALT_INDEX) || (slot == lqrsf_pkg::YAW_INDEX);
		target    = (slot == lqrsf_pkg::ALT_INDEX) ? altitude_target : yaw_target;
		diff      = {value[DW-1], value} - {target[DW-1], target};
		if (!offset_en) begin
			elem = value;
		end else if (diff[DW] != diff[DW-1]) begin
			elem = diff[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
		end else begin
			elem = diff[DW-1:0];
		end
	end

	// stage 1 control and element, gain row arrives from memory
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1.valid <= take;
			ctl_s1.first <= (slot == '0);
			ctl_s1.last  <= (slot == lqrsf_pkg::SLOT_W'(N_STATES - 1));
		end
	end

	always_ff @(posedge clk) begin
		if (adv && take) begin
			elem_s1 <= elem;
		end
	end

	// stage 2: four products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (adv) begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && ctl_s1.valid) begin
			for (int r = 0; r < NO; r++) begin
				prod_s2[r] <= $signed(gain_s1[r]) * elem_s1;
			end
		end
	end

	// saturating accumulate, first element restarts the sums
	always_comb begin
		for (int r = 0; r < NO; r++) begin
			logic [AW-1:0] base;
			logic [AW-1:0] raw;
			base = ctl_s2.first ? '0 : acc_q[r];
			raw  = base + prod_s2[r];
			if (base[AW-1] == prod_s2[r][AW-1] && raw[AW-1] != base[AW-1]) begin
				sum_nxt[r] = base[AW-1] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
			end else begin
				sum_nxt[r] = raw;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			if (ctl_s2.valid) begin
				acc_q <= sum_nxt;
			end
			valid_s3 <= ctl_s2.valid && ctl_s2.last;
		end
	end

	// snapshot of the sums for the output stage
	always_ff @(posedge clk) begin
		if (adv && ctl_s2.valid && ctl_s2.last) begin
			sum_s3 <= sum_nxt;
		end
	end

endmodule

// File: rtl/lqrsf_out.sv
module lqrsf_out (
	input  logic                                                 clk,
	input  logic                                                 arst_n,
	input  logic                                                 valid_s3,
	input  logic [lqrsf_pkg::N_OUTPUTS-1:0][lqrsf_pkg::ACC_W-1:0] sum_s3,
	input  logic signed [lqrsf_pkg::DATA_W-1:0]                  hover_thrust,
	input  logic                                                 res_stall,
	output logic                                                 hold,
	output logic                                                 res_valid,
	output lqrsf_pkg::result_t                                   res
);

	localparam int DW = lqrsf_pkg::DATA_W;
	localparam int NO = lqrsf_pkg::N_OUTPUTS;
	localparam int SW = lqrsf_pkg::SHR_W;
	localparam int FW = lqrsf_pkg::FIN_W;

	logic [NO-1:0][DW-1:0] lane;

	// floor shift, negate, hover offset on thrust, saturate
	always_comb begin
		for (int r = 0; r < NO; r++) begin
			logic signed [SW-1:0] shr;
			logic signed [FW-1:0] base;
			logic signed [FW-1:0] fin;
			shr  = $signed(sum_s3[r][lqrsf_pkg::ACC_W-1:lqrsf_pkg::FRAC_BITS]);
			base = (r == 0) ? FW'(hover_thrust) : '0;
			fin  = base - FW'(shr);
			if (fin > FW'(32'sh7fffffff)) begin
				lane[r] = {1'b0, {(DW-1){1'b1}}};
			end else if (fin < FW'(-33'sh080000000)) begin
				lane[r] = {1'b1, {(DW-1){1'b0}}};
			end else begin
				lane[r] = fin[DW-1:0];
			end
		end
	end

	// finished result waits in stage 3 while the output word is stalled
	assign hold = valid_s3 && res_valid && res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (valid_s3 && !hold) begin
			res_valid <= 1'b1;
		end else if (!res_stall) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3 && !hold) begin
			res.out_thrust <= lane[0];
			res.out_roll   <= lane[1];
			res.out_pitch  <= lane[2];
			res.out_yaw    <= lane[3];
		end
	end

endmodule

// File: rtl/lqr_state_feedback.sv
// LQR state feedback u = -K*x, four outputs, Q16.16. A kind-0 word writes one
// gain (address row*N_STATES+column); a kind-1 word carries state element
// "slot". Elements 2 and 5 are offset by the altitude and yaw targets. Every
// element reads its gain row (one lane per output) from the gain memory,
// multiplies in four lanes and adds into four saturating 64-bit accumulators;
// element 0 restarts them. Element N_STATES-1 passes stage 1, stage 2 and the
// stage-3 sums before its result word is registered. The input stalls only while
// a finished result sits behind a stalled output register. The gain memory is
// not cleared at reset: every gain used must have been written first.
module lqr_state_feedback #(
	parameter int N_STATES = lqrsf_pkg::N_STATES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  lqrsf_pkg::item_t                  item,
	output logic                              res_valid,
	input  logic                              res_stall,
	output lqrsf_pkg::result_t                res,
	input  logic                              cfg_we,
	input  logic [lqrsf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lqrsf_pkg::DATA_W-1:0]      cfg_data
);

	localparam int IDX_W = $clog2(N_STATES);
	localparam int DW    = lqrsf_pkg::DATA_W;
	localparam int NO    = lqrsf_pkg::N_OUTPUTS;

	logic signed [DW-1:0] altitude_target_q;
	logic signed [DW-1:0] yaw_target_q;
	logic signed [DW-1:0] hover_thrust_q;

	logic                          hold;
	logic                          adv;
	logic                          take_state;
	logic                          take_gain;
	logic [NO-1:0][DW-1:0]         gain_s1;
	logic                          valid_s3;
	logic [NO-1:0][lqrsf_pkg::ACC_W-1:0] sum_s3;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			altitude_target_q <= lqrsf_pkg::ALTITUDE_TARGET_RST;
			yaw_target_q      <= lqrsf_pkg::YAW_TARGET_RST;
			hover_thrust_q    <= lqrsf_pkg::HOVER_THRUST_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				lqrsf_pkg::CFG_ALTITUDE_TARGET: altitude_target_q <= cfg_data;
				lqrsf_pkg::CFG_YAW_TARGET:      yaw_target_q      <= cfg_data;
				lqrsf_pkg::CFG_HOVER_THRUST:    hover_thrust_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// input handshake and item decode
	assign adv        = !hold;
	assign item_stall = hold;
	assign take_gain  = item_valid && adv && (item.kind == lqrsf_pkg::KIND_GAIN);
	assign take_state = item_valid && adv && (item.kind == lqrsf_pkg::KIND_STATE) &&
	                    (32'(item.slot) < 32'(N_STATES));

	lqrsf_gain_mem #(
		.N_STATES (N_STATES)
	) u_gain_mem (
		.clk   (clk),
		.we    (take_gain),
		.wslot (item.slot),
		.wdata (item.value),
		.re    (take_state),
		.raddr (item.slot[IDX_W-1:0]),
		.rd_s1 (gain_s1)
	);

	lqrsf_mac #(
		.N_STATES (N_STATES)
	) u_mac (
		.clk             (clk),
		.arst_n          (arst_n),
		.adv             (adv),
		.take            (take_state),
		.slot            (item.slot),
		.value           (item.value),
		.altitude_target (altitude_target_q),
		.yaw_target      (yaw_target_q),
		.gain_s1         (gain_s1),
		.valid_s3        (valid_s3),
		.sum_s3          (sum_s3)
	);

	lqrsf_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s3     (valid_s3),
		.sum_s3       (sum_s3),
		.hover_thrust (hover_thrust_q),
		.res_stall    (res_stall),
		.hold         (hold),
		.res_valid    (res_valid),
		.res          (res)
	);

endmodule

// File: rtl/lqrsf_check.sv
module lqrsf_check #(
	parameter int N_STATES = lqrsf_pkg::N_STATES_DEF
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            item_valid,
	input logic                            item_stall,
	input lqrsf_pkg::item_t                item,
	input logic                            res_valid,
	input logic                            res_stall,
	input lqrsf_pkg::result_t              res
);

	logic last_taken;

	assign last_taken = item_valid && !item_stall && (item.kind == lqrsf_pkg::KIND_STATE) &&
	                    (item.slot == lqrsf_pkg::SLOT_W'(N_STATES - 1));

	// reset leaves no result and no input stall
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> !res_valid && !item_stall)
		else $error("result or stall during reset");

	// input stalls only behind a full, stalled output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> res_valid && res_stall)
		else $error("input stalled without a waiting result");

	// last element yields a result when the output keeps moving in between
	a_last_result: assert property (@(posedge clk) disable iff (!arst_n)
		last_taken ##1 !res_stall ##1 !res_stall ##1 !res_stall |=> res_valid)
		else $error("last element produced no result");

	// a stalled result word holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("stalled result word changed");

endmodule

bind lqr_state_feedback lqrsf_check #(.N_STATES(N_STATES)) u_lqrsf_check (.*);
